@@ rtl/core/rrts_pkg.sv @@
package rrts_pkg;

  localparam int MAX_SLOTS_DEF   = 16;
  localparam int STACK_BYTES_DEF = 4096;
  localparam logic [7:0] SLICE_RESET = 8'd10;

  // Request codes.
  localparam logic [2:0] REQ_TICK     = 3'd0;
  localparam logic [2:0] REQ_YIELD    = 3'd1;
  localparam logic [2:0] REQ_KILL     = 3'd2;
  localparam logic [2:0] REQ_CREATE   = 3'd3;
  localparam logic [2:0] REQ_START    = 3'd4;
  localparam logic [2:0] REQ_SET_PRIO = 3'd5;

  // Status codes.
  localparam logic [2:0] STS_OK          = 3'd0;
  localparam logic [2:0] STS_FULL        = 3'd1;
  localparam logic [2:0] STS_NONE        = 3'd2;
  localparam logic [2:0] STS_PRIO        = 3'd3;
  localparam logic [2:0] STS_NOT_STARTED = 3'd4;

  // Thread states.
  localparam logic [2:0] TS_FREE    = 3'd0;
  localparam logic [2:0] TS_READY   = 3'd1;
  localparam logic [2:0] TS_RUNNING = 3'd2;
  localparam logic [2:0] TS_WAIT    = 3'd3;
  localparam logic [2:0] TS_ZOMBIE  = 3'd4;

  typedef struct packed {
    logic [2:0]        req_type;
    logic [31:0]       current_sp;
    logic [31:0]       stack_base;
    logic signed [7:0] new_priority;
  } sched_req_t;

  typedef struct packed {
    logic [31:0] resume_sp;
    logic [3:0]  running_slot;
    logic [3:0]  created_slot;
    logic        switched;
    logic [2:0]  status_code;
  } sched_rsp_t;

  typedef struct packed {
    logic        present;
    logic [2:0]  status;
    logic [31:0] saved_sp;
    logic [31:0] base_sp;
    logic [31:0] cpu_ticks;
    logic [7:0]  quantum;
    logic [7:0]  prio;
  } slot_rec_t;

  // Time slice of a thread: base slice plus signed priority, clamped to 0..255.
  function automatic logic [7:0] quantum_for(input logic [7:0] slice, input logic [7:0] prio);
    logic signed [9:0] sum;
    sum = $signed({2'b00, slice}) + $signed({{2{prio[7]}}, prio});
    if (sum < 0) begin
      return 8'd0;
    end else if (sum > 10'sd255) begin
      return 8'hFF;
    end else begin
      return sum[7:0];
    end
  endfunction

  // A priority must lie strictly between minus and plus the base slice.
  function automatic logic prio_ok(input logic [7:0] slice, input logic [7:0] prio);
    logic signed [9:0] s;
    logic signed [9:0] p;
    s = $signed({2'b00, slice});
    p = $signed({{2{prio[7]}}, prio});
    return (p > -s) && (p < s);
  endfunction

endpackage

@@ rtl/core/rrts_slot_mem.sv @@
module rrts_slot_mem
  import rrts_pkg::*;
#(
  parameter int DEPTH  = MAX_SLOTS_DEF,
  parameter int ADDR_W = $clog2(MAX_SLOTS_DEF)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  slot_rec_t         wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output slot_rec_t         rd_data
);

  slot_rec_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // A read of the entry being written returns the new record.
  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr == rd_addr)) begin
      rd_data <= wr_data;
    end else begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/core/rrts_ctrl.sv @@
module rrts_ctrl
  import rrts_pkg::*;
#(
  parameter int MAX_SLOTS   = MAX_SLOTS_DEF,
  parameter int STACK_BYTES = STACK_BYTES_DEF,
  localparam int SLOT_W     = $clog2(MAX_SLOTS),
  localparam int CNT_W      = $clog2(MAX_SLOTS + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  input  sched_req_t        req,
  output logic              req_stall,
  input  logic [7:0]        slice_ticks,
  output logic              res_valid,
  input  logic              res_take,
  output sched_rsp_t        res,
  output logic              wr_en,
  output logic [SLOT_W-1:0] wr_addr,
  output slot_rec_t         wr_data,
  output logic [SLOT_W-1:0] rd_addr,
  input  slot_rec_t         rd_data
);

  localparam logic [31:0] STACK_OFS = 32'(STACK_BYTES - 60);
  localparam logic [CNT_W-1:0] SLOT_CNT = CNT_W'(MAX_SLOTS);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_SCAN = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t            state;
  sched_req_t        req_q;
  logic [SLOT_W-1:0] cur;
  logic [CNT_W-1:0]  tc;
  logic              running;
  logic [SLOT_W-1:0] scan_idx;
  logic [CNT_W-1:0]  remain;

  slot_rec_t mod_rec;
  slot_rec_t tick_rec;
  slot_rec_t sw_rec;
  slot_rec_t new_rec;
  slot_rec_t start_rec;
  slot_rec_t prio_rec;
  slot_rec_t run_rec;
  logic      is_sched;
  logic      quant_nz;
  logic      table_full;
  logic      start_ok;
  logic      prio_fits;
  logic      candidate;
  logic      create_go;
  logic      start_go;
  logic      scan_go;
  logic [2:0] exec_status;

  // Slots are handed out in order and never reused, so the allocated slots are
  // always 0 .. tc-1 and the search wraps at the fill count.
  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    logic [CNT_W-1:0] n;
    n = CNT_W'(s) + CNT_W'(1);
    return (n == tc) ? '0 : n[SLOT_W-1:0];
  endfunction

  assign req_stall = (state != S_IDLE);
  assign res_valid = (state == S_DONE);

  always_comb begin
    is_sched   = (req_q.req_type == REQ_TICK) || (req_q.req_type == REQ_YIELD) ||
                 (req_q.req_type == REQ_KILL);
    table_full = (tc >= SLOT_CNT);
    start_ok   = (tc != '0) && rd_data.present;
    prio_fits  = prio_ok(slice_ticks, req_q.new_priority);
    candidate  = rd_data.present &&
                 ((rd_data.status == TS_READY) || (rd_data.status == TS_WAIT));

    mod_rec = rd_data;
    if (req_q.req_type == REQ_KILL) begin
      mod_rec.status  = TS_ZOMBIE;
      mod_rec.present = 1'b0;
      mod_rec.quantum = 8'd0;
    end else if (req_q.req_type == REQ_YIELD) begin
      mod_rec.quantum = 8'd0;
    end
    quant_nz = (mod_rec.quantum != 8'd0);

    create_go = (req_q.req_type == REQ_CREATE) && !table_full;
    start_go  = (req_q.req_type == REQ_START) && start_ok;
    scan_go   = is_sched && running && !quant_nz && (tc != '0);

    exec_status = STS_OK;
    if (is_sched) begin
      if (!running) begin
        exec_status = STS_NOT_STARTED;
      end else if (!quant_nz && (tc == '0)) begin
        exec_status = STS_NONE;
      end
    end else if (req_q.req_type == REQ_CREATE) begin
      if (table_full) begin
        exec_status = STS_FULL;
      end
    end else if (req_q.req_type == REQ_START) begin
      if (!start_ok) begin
        exec_status = STS_NOT_STARTED;
      end
    end else if (req_q.req_type == REQ_SET_PRIO) begin
      if (!running) begin
        exec_status = STS_NOT_STARTED;
      end else if (!prio_fits) begin
        exec_status = STS_PRIO;
      end
    end

    tick_rec           = mod_rec;
    tick_rec.cpu_ticks = mod_rec.cpu_ticks + 32'd1;
    tick_rec.quantum   = mod_rec.quantum - 8'd1;

    // Leaving thread: a zombie is released, anything else is parked waiting.
    sw_rec = mod_rec;
    if (mod_rec.status == TS_ZOMBIE) begin
      sw_rec.saved_sp = mod_rec.base_sp;
      sw_rec.status   = TS_FREE;
    end else begin
      sw_rec.cpu_ticks = mod_rec.cpu_ticks + 32'd1;
      sw_rec.saved_sp  = req_q.current_sp;
      sw_rec.status    = TS_WAIT;
    end

    new_rec.present   = 1'b1;
    new_rec.status    = TS_READY;
    new_rec.saved_sp  = req_q.stack_base + STACK_OFS;
    new_rec.base_sp   = req_q.stack_base;
    new_rec.cpu_ticks = 32'd0;
    new_rec.quantum   = 8'd0;
    new_rec.prio      = 8'd0;

    start_rec           = rd_data;
    start_rec.cpu_ticks = 32'd0;
    start_rec.quantum   = 8'd0;

    prio_rec      = rd_data;
    prio_rec.prio = req_q.new_priority;

    run_rec         = rd_data;
    run_rec.quantum = quantum_for(slice_ticks, rd_data.prio);
    run_rec.status  = TS_RUNNING;

    wr_en   = 1'b0;
    wr_addr = cur;
    wr_data = rd_data;
    rd_addr = cur;

    unique case (state)
      S_IDLE: begin
        rd_addr = (req.req_type == REQ_START) ? '0 : cur;
      end
      S_EXEC: begin
        rd_addr = next_slot(cur);
        if (is_sched && running) begin
          wr_en   = 1'b1;
          wr_data = quant_nz ? tick_rec : sw_rec;
        end else if ((req_q.req_type == REQ_CREATE) && !table_full) begin
          wr_en   = 1'b1;
          wr_addr = tc[SLOT_W-1:0];
          wr_data = new_rec;
        end else if ((req_q.req_type == REQ_START) && start_ok) begin
          wr_en   = 1'b1;
          wr_addr = '0;
          wr_data = start_rec;
        end else if ((req_q.req_type == REQ_SET_PRIO) && running && prio_fits) begin
          wr_en   = 1'b1;
          wr_data = prio_rec;
        end
      end
      S_SCAN: begin
        rd_addr = next_slot(scan_idx);
        if (candidate) begin
          wr_en   = 1'b1;
          wr_addr = scan_idx;
          wr_data = run_rec;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      tc      <= '0;
      cur     <= '0;
      running <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            req_q <= req;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          res.resume_sp    <= req_q.current_sp;
          res.running_slot <= start_go ? 4'd0 : 4'(cur);
          res.created_slot <= create_go ? 4'(tc) : 4'd0;
          res.switched     <= 1'b0;
          res.status_code  <= exec_status;
          state            <= scan_go ? S_SCAN : S_DONE;
          if (scan_go) begin
            scan_idx <= next_slot(cur);
            remain   <= tc;
          end
          if (create_go) begin
            tc <= tc + CNT_W'(1);
          end
          if (start_go) begin
            cur     <= '0;
            running <= 1'b1;
          end
        end
        S_SCAN: begin
          if (candidate) begin
            cur              <= scan_idx;
            res.resume_sp    <= rd_data.saved_sp;
            res.running_slot <= 4'(scan_idx);
            res.switched     <= 1'b1;
            state            <= S_DONE;
          end else if (remain == CNT_W'(1)) begin
            res.status_code <= STS_NONE;
            state           <= S_DONE;
          end else begin
            scan_idx <= next_slot(scan_idx);
            remain   <= remain - CNT_W'(1);
          end
        end
        S_DONE: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_cur_live: assert property (@(posedge clk) disable iff (rst)
    running |-> (CNT_W'(cur) < tc))
    else $error("running slot lies beyond the allocated slots");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    tc <= SLOT_CNT)
    else $error("thread count exceeds the table size");

  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> ((remain != '0) && (remain <= tc) && (CNT_W'(scan_idx) < tc)))
    else $error("slot search outside the allocated slots");

  a_write_range: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (CNT_W'(wr_addr) <= tc))
    else $error("slot table written beyond the next free slot");

endmodule

@@ rtl/core/round_robin_timeslice_scheduler_core.sv @@
// An accepted request passes the controller's execute and done states, and rsp_valid rises when
// the result enters the response register; a switch adds a search that walks k slots (k from 1 to
// the number of created threads). The controller holds one request at a time and stalls the next
// until the result is taken; the slot search reads one entry of the slot table memory per cycle.
// Reset (synchronous) empties the table, stops the scheduler and sets slice_ticks to 10.
module round_robin_timeslice_scheduler_core
  import rrts_pkg::*;
#(
  parameter int MAX_SLOTS   = MAX_SLOTS_DEF,
  parameter int STACK_BYTES = STACK_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  input  logic       req_valid,
  output logic       req_stall,
  input  sched_req_t req,
  output logic       rsp_valid,
  input  logic       rsp_stall,
  output sched_rsp_t rsp
);

  localparam int SLOT_W = $clog2(MAX_SLOTS);

  logic [7:0]        slice_ticks;
  logic              res_valid;
  logic              res_take;
  sched_rsp_t        res;
  logic              wr_en;
  logic [SLOT_W-1:0] wr_addr;
  slot_rec_t         wr_data;
  logic [SLOT_W-1:0] rd_addr;
  slot_rec_t         rd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      slice_ticks <= SLICE_RESET;
    end else if (cfg_wr_en) begin
      slice_ticks <= cfg_wr_data;
    end
  end

  // The response register frees the controller to take the next request
  // while the previous response still waits.
  assign res_take = res_valid && (!rsp_valid || !rsp_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_take) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      rsp <= res;
    end
  end

  rrts_ctrl #(
    .MAX_SLOTS   (MAX_SLOTS),
    .STACK_BYTES (STACK_BYTES)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req         (req),
    .req_stall   (req_stall),
    .slice_ticks (slice_ticks),
    .res_valid   (res_valid),
    .res_take    (res_take),
    .res         (res),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data)
  );

  rrts_slot_mem #(
    .DEPTH  (MAX_SLOTS),
    .ADDR_W (SLOT_W)
  ) u_slot_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule
